@@ sv/tbbe_pkg.sv @@
// Package for the trivariate Bernstein basis evaluator: widths, commands and helpers.
// Used by the top level, controller, datapath and checker; depends on nothing.
package tbbe_pkg;
	localparam int MAX_DEGREE = 5;
	localparam int MAX_BASIS = 64;
	localparam int IDX_W = $clog2(MAX_BASIS);
	localparam int MAG_W = 41;
	localparam logic [MAG_W-1:0] ACC_LIMIT = {1'b1, {(MAG_W-1){1'b0}}};
	localparam logic [MAG_W-1:0] ONE_Q24 = MAG_W'(1) << 24;

	localparam logic [0:0] OP_LOAD = 1'b0;
	localparam logic [0:0] OP_EVAL = 1'b1;

	localparam logic [0:0] REG_DEGREE = 1'b0;
	localparam logic [0:0] REG_COUNT = 1'b1;

	function automatic logic [6:0] fact(input logic [2:0] n);
		logic [6:0] r;
		begin
			case (n) inside
				3'd0, 3'd1: r = 7'd1;
				3'd2: r = 7'd2;
				3'd3: r = 7'd6;
				3'd4: r = 7'd24;
				default: r = 7'd120;
			endcase
			return r;
		end
	endfunction

	// Truncating division of a partial weight by n!. The weight never exceeds 5! = 120,
	// so 6! and 7! always give zero, and a division by 3 is a multiply by 43/128.
	function automatic logic [6:0] div_fact(input logic [6:0] w, input logic [2:0] n);
		logic [13:0] t;
		logic [6:0] q;
		begin
			t = '0;
			case (n) inside
				3'd0, 3'd1: q = w;
				3'd2: q = w >> 1;
				3'd3: begin
					t = 14'(w >> 1) * 14'd43;
					q = t[13:7];
				end
				3'd4: begin
					t = 14'(w >> 3) * 14'd43;
					q = t[13:7];
				end
				3'd5: q = (w >= 7'd120) ? 7'd1 : 7'd0;
				default: q = 7'd0;
			endcase
			return q;
		end
	endfunction

	// Multinomial weight via successive truncating divisions by constant factorials.
	function automatic logic [6:0] weight(input logic [2:0] d, input logic [2:0] a,
			input logic [2:0] b, input logic [2:0] c, input logic [2:0] e);
		logic [6:0] w;
		begin
			w = fact(d);
			w = div_fact(w, a);
			w = div_fact(w, b);
			w = div_fact(w, c);
			w = div_fact(w, e);
			return w;
		end
	endfunction

	typedef struct packed {
		logic pw_start;
		logic pw_step;
		logic [1:0] pw_coord;
		logic ev_init;
		logic ev_step;
		logic [1:0] ev_coord;
		logic emit;
		logic mul_lo;
		logic mul_pw;
	} dp_cmd_t;
endpackage

@@ sv/tetra_bernstein_basis_eval.sv @@
// Top level of the trivariate Bernstein basis evaluator.
// Depends on tbbe_pkg, tbbe_ram, tbbe_ctrl and tbbe_datapath.
// A load transaction writes one table entry. An evaluate
// transaction first builds powers 2..5 of w, x, y and z (sixteen products, each formed from
// a low and a high slice on the shared multiplier), then handles each entry in turn (table read,
// four products, emit), so busy stays high until the last entry is emitted and
// the last result follows in the first cycle after busy falls. Results appear on
// basis_index, basis_value and last_value for one cycle each, flagged by result_valid;
// the receiver cannot stall them. A basis_count of zero yields no results and no busy.
module tetra_bernstein_basis_eval (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [0:0] operation,
	input logic [5:0] entry_index,
	input logic [2:0] exp_w,
	input logic [2:0] exp_x,
	input logic [2:0] exp_y,
	input logic [2:0] exp_z,
	input logic signed [17:0] coord_x,
	input logic signed [17:0] coord_y,
	input logic signed [17:0] coord_z,
	output logic result_valid,
	output logic [5:0] basis_index,
	output logic signed [31:0] basis_value,
	output logic [0:0] last_value,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:2] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import tbbe_pkg::*;
	logic [2:0] degree_q;
	logic [6:0] count_q;
	logic signed [17:0] cx_q, cy_q, cz_q;
	logic [2:0] deg_eff;
	logic accept, load, go;
	dp_cmd_t cmd;
	logic [2:0] pw_k;
	logic [IDX_W-1:0] ridx, eidx;
	logic elast;
	logic [11:0] code;
	logic [6:0] wt;

	assign pready = 1'b1;
	assign deg_eff = (degree_q > 3'(MAX_DEGREE)) ? 3'(MAX_DEGREE) : degree_q;
	assign accept = start && !busy;
	assign load = accept && (operation == OP_LOAD);
	assign go = accept && (operation == OP_EVAL);
	assign prdata = (paddr[2] == REG_DEGREE) ? {29'd0, degree_q} : {25'd0, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= 3'd1;
			count_q <= 7'd1;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_DEGREE) degree_q <= pwdata[2:0];
			else count_q <= pwdata[6:0];
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			cx_q <= coord_x;
			cy_q <= coord_y;
			cz_q <= coord_z;
		end
	end

	tbbe_ram #(.WIDTH(12), .DEPTH(MAX_BASIS)) u_exp (
		.clk(clk), .we(load), .waddr(entry_index[IDX_W-1:0]),
		.wdata({exp_z, exp_y, exp_x, exp_w}), .raddr(ridx), .rdata(code));
	tbbe_ram #(.WIDTH(7), .DEPTH(MAX_BASIS)) u_wt (
		.clk(clk), .we(load), .waddr(entry_index[IDX_W-1:0]),
		.wdata(weight(deg_eff, exp_w, exp_x, exp_y, exp_z)), .raddr(ridx), .rdata(wt));

	tbbe_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .go(go), .count(count_q), .busy(busy), .cmd(cmd),
		.pw_k(pw_k), .ridx(ridx), .eidx(eidx), .elast(elast));

	tbbe_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .pw_k(pw_k),
		.cx(go ? coord_x : cx_q), .cy(go ? coord_y : cy_q), .cz(go ? coord_z : cz_q),
		.code(code), .wt(wt), .deg(deg_eff), .eidx(eidx), .elast(elast),
		.ostb(result_valid), .oidx(basis_index), .oval(basis_value), .olast(last_value));
endmodule

@@ sv/tbbe_ram.sv @@
// Generic single-port-write, registered-read RAM.
// No dependencies.
module tbbe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

@@ sv/tbbe_datapath.sv @@
// Datapath: power table, shared rounding multiplier and output saturation.
// Depends on tbbe_pkg.
module tbbe_datapath (
	input logic clk,
	input logic arst_n,
	input tbbe_pkg::dp_cmd_t cmd,
	input logic [2:0] pw_k,
	input logic signed [17:0] cx,
	input logic signed [17:0] cy,
	input logic signed [17:0] cz,
	input logic [11:0] code,
	input logic [6:0] wt,
	input logic [2:0] deg,
	input logic [tbbe_pkg::IDX_W-1:0] eidx,
	input logic elast,
	output logic ostb,
	output logic [tbbe_pkg::IDX_W-1:0] oidx,
	output logic [31:0] oval,
	output logic olast
);
	import tbbe_pkg::*;
	logic [MAG_W-1:0] pmag_q [4][MAX_DEGREE+1];
	logic pneg_q [4][MAX_DEGREE+1];
	logic [19:0] bm_q [4];
	logic bn_q [4];
	logic [MAG_W-1:0] acc_q;
	logic neg_q, zero_q;
	logic [61:0] part_q;

	logic signed [19:0] b [4];
	logic [MAG_W-1:0] ma, mb, mres;
	logic [4:0] sh;
	logic [2:0] ex;
	logic [20:0] mslice;
	logic [61:0] pm;
	logic [81:0] prod;
	logic [81:0] rnd;

	always_comb begin
		b[1] = 20'(cx);
		b[2] = 20'(cy);
		b[3] = 20'(cz);
		b[0] = 20'sd65536 - b[1] - b[2] - b[3];
		ex = code[3*cmd.ev_coord +: 3];
		if (cmd.mul_pw) begin
			ma = pmag_q[cmd.pw_coord][pw_k - 3'd1];
			mb = MAG_W'(bm_q[cmd.pw_coord]);
			sh = 5'd16;
		end else begin
			ma = acc_q;
			mb = pmag_q[cmd.ev_coord][ex];
			sh = 5'd24;
		end
		// A product is formed from the low slice of mb first, then the high slice.
		mslice = cmd.mul_lo ? mb[20:0] : {1'b0, mb[MAG_W-1:21]};
		pm = 62'(ma) * 62'(mslice);
		prod = 82'(part_q) + (82'(pm) << 21);
		rnd = (prod + (82'(1) << (sh - 5'd1))) >> sh;
		// A product that does not fit in 63 bits clamps, as does an oversized result.
		if (ma == '0 || mb == '0) mres = '0;
		else if (prod[81:63] != '0 || rnd > 82'(ACC_LIMIT)) mres = ACC_LIMIT;
		else mres = rnd[MAG_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_lo) part_q <= pm;
		if (cmd.pw_start) begin
			for (int c = 0; c < 4; c++) begin
				bn_q[c] <= b[c][19];
				bm_q[c] <= b[c][19] ? 20'(-b[c]) : b[c];
				pmag_q[c][0] <= ONE_Q24;
				pneg_q[c][0] <= 1'b0;
				pmag_q[c][1] <= MAG_W'(b[c][19] ? 20'(-b[c]) : b[c]) << 8;
				pneg_q[c][1] <= b[c][19];
			end
		end
		if (cmd.pw_step) begin
			pmag_q[cmd.pw_coord][pw_k] <= mres;
			pneg_q[cmd.pw_coord][pw_k] <= pneg_q[cmd.pw_coord][pw_k - 3'd1] ^ bn_q[cmd.pw_coord];
		end
		if (cmd.ev_init) begin
			acc_q <= MAG_W'(wt) << 24;
			neg_q <= 1'b0;
			zero_q <= 1'b0;
		end else if (cmd.ev_step) begin
			if (ex > deg) zero_q <= 1'b1;
			else begin
				acc_q <= mres;
				neg_q <= neg_q ^ pneg_q[cmd.ev_coord][ex];
			end
		end
		if (cmd.emit) begin
			oidx <= eidx;
			olast <= elast;
			if (zero_q || acc_q == '0) oval <= '0;
			else if (neg_q) oval <= (acc_q >= MAG_W'(32'h8000_0000)) ? 32'h8000_0000
				: 32'(~acc_q + MAG_W'(1));
			else oval <= (acc_q > MAG_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : acc_q[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ostb <= 1'b0;
		else ostb <= cmd.emit;
	end
endmodule

@@ sv/tbbe_ctrl.sv @@
// Controller: sequences power build, per-entry products and result emission.
// Depends on tbbe_pkg.
module tbbe_ctrl (
	input logic clk,
	input logic arst_n,
	input logic go,
	input logic [6:0] count,
	output logic busy,
	output tbbe_pkg::dp_cmd_t cmd,
	output logic [2:0] pw_k,
	output logic [tbbe_pkg::IDX_W-1:0] ridx,
	output logic [tbbe_pkg::IDX_W-1:0] eidx,
	output logic elast
);
	import tbbe_pkg::*;
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001, S_POW = 5'b00010, S_RD = 5'b00100,
		S_MUL = 5'b01000, S_EMIT = 5'b10000
	} state_t;
	state_t state_q;
	logic [2:0] k_q;
	logic [1:0] c_q;
	logic ph_q;
	logic [IDX_W:0] i_q, n_q;

	assign busy = (state_q != S_IDLE);
	assign pw_k = k_q;
	// The table read is registered, so the next entry is addressed while emitting.
	assign ridx = (state_q == S_EMIT) ? i_q[IDX_W-1:0] + 1'b1 : i_q[IDX_W-1:0];
	assign eidx = i_q[IDX_W-1:0];
	assign elast = (i_q + 1'b1 == n_q);

	always_comb begin
		cmd = '0;
		cmd.pw_start = (state_q == S_IDLE) && go;
		cmd.pw_step = (state_q == S_POW) && ph_q;
		cmd.pw_coord = c_q;
		cmd.ev_init = (state_q == S_RD);
		cmd.ev_step = (state_q == S_MUL) && ph_q;
		cmd.ev_coord = c_q;
		cmd.emit = (state_q == S_EMIT);
		cmd.mul_lo = ((state_q == S_POW) || (state_q == S_MUL)) && !ph_q;
		cmd.mul_pw = (state_q == S_POW);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q <= '0;
			c_q <= '0;
			ph_q <= 1'b0;
			i_q <= '0;
			n_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (go) begin
					n_q <= (count > 7'(MAX_BASIS)) ? (IDX_W+1)'(MAX_BASIS)
						: (IDX_W+1)'(count);
					k_q <= 3'd2;
					c_q <= '0;
					ph_q <= 1'b0;
					i_q <= '0;
					state_q <= (count == 7'd0) ? S_IDLE : S_POW;
				end
				S_POW: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						if (k_q == 3'(MAX_DEGREE)) begin
							k_q <= 3'd2;
							c_q <= c_q + 2'd1;
							if (c_q == 2'd3) state_q <= S_RD;
						end else k_q <= k_q + 3'd1;
					end
				end
				S_RD: begin
					c_q <= '0;
					ph_q <= 1'b0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						c_q <= c_q + 2'd1;
						if (c_q == 2'd3) state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					i_q <= i_q + 1'b1;
					state_q <= elast ? S_IDLE : S_RD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ sv/tbbe_checker.sv @@
// Port-level checker for the Bernstein basis evaluator, bound to the top level.
// Depends on tbbe_pkg and the top level's ports.
module tbbe_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic [0:0] operation,
	input logic result_valid,
	input logic [0:0] last_value
);
	import tbbe_pkg::*;
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == OP_LOAD) |=> !busy) else $error("load set busy");
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_value |-> busy) else $error("result outside run");
	a_no_b2b: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("results back to back");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_value |-> !busy) else $error("busy after last");
endmodule

bind tetra_bernstein_basis_eval tbbe_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .operation(operation),
	.result_valid(result_valid), .last_value(last_value));

@@ tb/sv/testbench.sv @@
// Self-checking testbench for tetra_bernstein_basis_eval: loads basis tables, evaluates
// points and compares every result with a behavioral Bernstein evaluator. Depends on tbbe_pkg.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import tbbe_pkg::*;

	typedef struct {
		logic [0:0] op;
		logic [5:0] idx;
		logic [2:0] ew, ex, ey, ez;
		logic signed [17:0] cx, cy, cz;
	} cmd_t;

	typedef struct {
		logic [5:0] idx;
		logic signed [31:0] val;
		logic last;
	} basis_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [0:0] operation = OP_LOAD;
	logic [5:0] entry_index = '0;
	logic [2:0] exp_w = '0, exp_x = '0, exp_y = '0, exp_z = '0;
	logic signed [17:0] coord_x = '0, coord_y = '0, coord_z = '0;
	logic result_valid;
	logic [5:0] basis_index;
	logic signed [31:0] basis_value;
	logic [0:0] last_value;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:2] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	tetra_bernstein_basis_eval u_dut (.*);

	cmd_t pending_cmds[$];
	basis_t expected_vals[$];
	int errors = 0;
	int cycles = 0;
	int gap_left = 0;
	bit idle_on = 1'b1;

	// Evaluator state.
	logic [11:0] exps_mdl[64];
	logic [6:0] wts_mdl[64];
	int deg_mdl = 1;
	int count_mdl = 1;

	initial forever #5 clk = ~clk;

	function automatic longint unsigned fct(int n);
		longint unsigned r = 1;
		for (int i = 2; i <= n; i++) r *= i;
		return r;
	endfunction

	function automatic longint unsigned scale_mul(longint unsigned a, longint unsigned b,
			int sh);
		longint unsigned r;
		if (a == 0 || b == 0) return 0;
		if (b > (64'hFFFF_FFFF_FFFF_FFFF / 2) / a) return 64'd1 << 40;
		r = (a * b + (64'd1 << (sh - 1))) >> sh;
		return (r > (64'd1 << 40)) ? (64'd1 << 40) : r;
	endfunction

	// Applies one accepted command: a load updates the table, an evaluate queues the values it yields.
	task automatic predict_basis(cmd_t c);
		longint signed b[4];
		longint unsigned pm[4][6];
		bit pn[4][6];
		longint unsigned acc, w;
		bit ng, bn;
		int d, e;
		longint unsigned bm;
		basis_t r;
		d = (deg_mdl > MAX_DEGREE) ? MAX_DEGREE : deg_mdl;
		if (c.op == OP_LOAD) begin
			w = fct(d) / fct(c.ew) / fct(c.ex) / fct(c.ey) / fct(c.ez);
			exps_mdl[c.idx] = {c.ez, c.ey, c.ex, c.ew};
			wts_mdl[c.idx] = w[6:0];
			return;
		end
		b[1] = c.cx;
		b[2] = c.cy;
		b[3] = c.cz;
		b[0] = 65536 - b[1] - b[2] - b[3];
		for (int k = 0; k < 4; k++) begin
			bn = b[k] < 0;
			bm = bn ? -b[k] : b[k];
			pm[k][0] = 64'd1 << 24;
			pn[k][0] = 1'b0;
			for (int p = 1; p <= 5; p++) begin
				pm[k][p] = (p == 1) ? (bm << 8) : scale_mul(pm[k][p-1], bm, 16);
				pn[k][p] = pn[k][p-1] ^ bn;
			end
		end
		for (int i = 0; i < count_mdl; i++) begin
			acc = longint'(wts_mdl[i]) << 24;
			ng = 1'b0;
			for (int k = 0; k < 4; k++) begin
				e = exps_mdl[i][3*k +: 3];
				if (e > d) begin
					acc = 0;
					break;
				end
				acc = scale_mul(acc, pm[k][e], 24);
				ng ^= pn[k][e];
			end
			r.idx = 6'(i);
			if (acc == 0) r.val = 0;
			else if (ng) r.val = (acc >= 64'h8000_0000) ? 32'h8000_0000 : -acc[31:0];
			else r.val = (acc > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : acc[31:0];
			r.last = (i + 1 == count_mdl);
			expected_vals.push_back(r);
		end
	endtask

	// Driver: offers the next command, with random gaps while idling is on.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				predict_basis(pending_cmds.pop_front());
				if (idle_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 14);
			end
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_cmds.size() > 0 && !(start && !busy && pending_cmds.size() == 0)) begin
				start <= 1'b1;
				operation <= pending_cmds[0].op;
				entry_index <= pending_cmds[0].idx;
				exp_w <= pending_cmds[0].ew;
				exp_x <= pending_cmds[0].ex;
				exp_y <= pending_cmds[0].ey;
				exp_z <= pending_cmds[0].ez;
				coord_x <= pending_cmds[0].cx;
				coord_y <= pending_cmds[0].cy;
				coord_z <= pending_cmds[0].cz;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: checks every result strobe against the oldest expected value.
	always @(posedge clk) begin
		cycles++;
		if (arst_n && result_valid) begin
			if (expected_vals.size() == 0) begin
				$display("%0t: unexpected result idx %0d val %0h", $time, basis_index,
					basis_value);
				errors++;
			end else begin
				basis_t x;
				x = expected_vals.pop_front();
				if (basis_index !== x.idx || basis_value !== x.val ||
						last_value !== x.last)
					begin
					$display("%0t: expected idx %0d val %0h last %0d, got idx %0d val %0h last %0d",
						$time, x.idx, x.val, x.last, basis_index, basis_value, last_value);
					errors++;
				end
			end
		end
		if (cycles > 400000) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic apb_write(logic [2:2] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == REG_DEGREE) deg_mdl = data[2:0];
		else count_mdl = (data[6:0] > MAX_BASIS) ? MAX_BASIS : data[6:0];
	endtask

	// Waits until the command queue drains, every value has arrived and the block is idle.
	task automatic drain();
		while (pending_cmds.size() > 0 || start || expected_vals.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic signed [17:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 18'sh1FFFF;
			1: return -18'sh20000;
			2: return 18'sd0;
			3: return 18'($urandom_range(0, 65536));
			default: return 18'($urandom());
		endcase
	endfunction

	function automatic cmd_t mk_load(int idx, int a, int b, int c, int e);
		cmd_t m;
		m.op = OP_LOAD;
		m.idx = 6'(idx);
		m.ew = 3'(a);
		m.ex = 3'(b);
		m.ey = 3'(c);
		m.ez = 3'(e);
		m.cx = 18'($urandom());
		m.cy = 18'($urandom());
		m.cz = 18'($urandom());
		return m;
	endfunction

	function automatic cmd_t mk_eval(logic signed [17:0] x, y, z);
		cmd_t m;
		m.op = OP_EVAL;
		m.idx = 6'($urandom());
		{m.ew, m.ex, m.ey, m.ez} = 12'($urandom());
		m.cx = x;
		m.cy = y;
		m.cz = z;
		return m;
	endfunction

	// Loads the first cnt entries at the current degree; exponents above degree are
	// occasional.
	task automatic fill_table(int d, int cnt);
		int a, b, c;
		for (int i = 0; i < cnt; i++) begin
			a = $urandom_range(0, d);
			b = $urandom_range(0, d - a);
			c = $urandom_range(0, d - a - b);
			if ($urandom_range(0, 9) == 0)
				pending_cmds.push_back(mk_load(i, $urandom_range(0, 7), $urandom_range(0, 7),
					$urandom_range(0, 7), $urandom_range(0, 7)));
			else
				pending_cmds.push_back(mk_load(i, a, b, c, d - a - b - c));
		end
	endtask

	initial begin
		int d, n;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at degree 5 with a small table.
		apb_write(REG_DEGREE, 5);
		apb_write(REG_COUNT, 6);
		pending_cmds.push_back(mk_load(0, 5, 0, 0, 0));
		pending_cmds.push_back(mk_load(1, 0, 5, 0, 0));
		pending_cmds.push_back(mk_load(2, 1, 1, 2, 1));
		pending_cmds.push_back(mk_load(3, 7, 7, 7, 7));
		pending_cmds.push_back(mk_load(4, 2, 1, 1, 1));
		pending_cmds.push_back(mk_load(5, 0, 0, 0, 5));
		pending_cmds.push_back(mk_load(63, 1, 1, 1, 2));
		pending_cmds.push_back(mk_eval(18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF));
		pending_cmds.push_back(mk_eval(-18'sh20000, -18'sh20000, -18'sh20000));
		pending_cmds.push_back(mk_eval(18'sd16384, 18'sd16384, 18'sd0));
		pending_cmds.push_back(mk_eval(18'sd0, 18'sd0, 18'sd0));
		pending_cmds.push_back(mk_eval(18'sd65536, -18'sd1, 18'sd1));
		drain();
		// Lower the degree so stored exponents exceed it, then a zero count.
		apb_write(REG_DEGREE, 2);
		pending_cmds.push_back(mk_eval(18'sd21845, 18'sd21845, 18'sd0));
		drain();
		apb_write(REG_COUNT, 0);
		pending_cmds.push_back(mk_eval(18'sd100, 18'sd200, 18'sd300));
		drain();
		apb_write(REG_DEGREE, 7);
		apb_write(REG_COUNT, 127);
		fill_table(5, 64);
		pending_cmds.push_back(mk_eval(18'sd30000, 18'sd20000, 18'sd10000));
		drain();

		// Random phases over several settings; the whole table is written by now.
		for (int ph = 0; ph < 6; ph++) begin
			d = (ph == 0) ? 1 : $urandom_range(1, 5);
			n = (ph == 1) ? 1 : (ph == 2) ? 64 : $urandom_range(1, 12);
			if (ph == 5) idle_on = 1'b0;
			apb_write(REG_DEGREE, d);
			apb_write(REG_COUNT, n);
			fill_table(d, (n > 8) ? 8 : n);
			for (int k = 0; k < 12; k++) begin
				if ($urandom_range(0, 4) == 0)
					pending_cmds.push_back(mk_load($urandom_range(0, 63),
						$urandom_range(0, d), $urandom_range(0, 7), 0, 0));
				else
					pending_cmds.push_back(mk_eval(rand_coord(), rand_coord(),
						$urandom_range(0, 1) ? 18'sd0 : rand_coord()));
			end
			drain();
		end

		if (errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end
endmodule
